>>> rtl/tspwm_pkg.sv
// Shared types and constants for the three-channel servo pulse generator.
`timescale 1ns / 1ps
`default_nettype none

package tspwm_pkg;

   // Timer ticks per microsecond and radian gain (Q6 of ticks per radian)
   localparam int TICKS_PER_US = 3;
   localparam logic [15:0] RAD_GAIN_Q6 = 16'd61115;

   localparam int NUM_CH = 3;

   // Neutral width in ticks and signed set-point sum widths
   localparam int BASE_W = 15 + $clog2(TICKS_PER_US + 1);
   localparam int SUM_W  = BASE_W + 2;

   // Reset values
   localparam logic [15:0] RESET_PERIOD  = 16'd60000;
   localparam logic [14:0] RESET_NEUTRAL = 15'd1500;
   localparam logic [15:0] RESET_COMPARE = 16'd4500;
   localparam logic [14:0] RESET_COMPARE_US = 15'(4500 / TICKS_PER_US);
   localparam logic [BASE_W-1:0] RESET_BASE = BASE_W'(1500 * TICKS_PER_US);

   // Reciprocal for ticks-to-microseconds: exact for any 16-bit count
   localparam int US_SHIFT    = 20;
   localparam int US_RECIP_W  = US_SHIFT + 1;
   localparam logic [US_RECIP_W-1:0] US_RECIP =
      US_RECIP_W'((2 ** US_SHIFT + TICKS_PER_US - 1) / TICKS_PER_US);

   // Reciprocal of three, exact for values below 2**17 (degrees: /8 then /3)
   localparam int DEG_SHIFT = 18;
   localparam logic [16:0] DEG_RECIP = 17'((2 ** DEG_SHIFT + 2) / 3);

   // Radian quotient rounding toward zero
   localparam int RAD_SHIFT = 18;

   // Request kinds
   typedef enum logic [1:0] {
      REQ_TICK    = 2'd0,
      REQ_SET_US  = 2'd1,
      REQ_SET_RAD = 2'd2,
      REQ_SET_DEG = 2'd3
   } req_kind_type;

   // Configuration register indexes, one 32-bit word each
   typedef enum logic [2:0] {
      CSR_PERIOD   = 3'd0,
      CSR_ENABLE   = 3'd1,
      CSR_NEUTRAL0 = 3'd2,
      CSR_NEUTRAL1 = 3'd3,
      CSR_NEUTRAL2 = 3'd4
   } csr_index_type;

   // Channel code that addresses no servo
   localparam logic [1:0] CH_NONE = 2'd3;

   // Finished set-point handed to the commit stage
   typedef struct packed {
      logic          valid;
      req_kind_type  req_type;
      logic [1:0]    channel;
      logic [15:0]   cand_ticks;
      logic [14:0]   cand_us;
   } cmd_type;

endpackage

`default_nettype wire

>>> rtl/tspwm_setpoint.sv
// Set-point pipeline: request register, products, saturated compare value, microsecond value.
`timescale 1ns / 1ps
`default_nettype none

module tspwm_setpoint
   import tspwm_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_type,
   input  wire logic [1:0]                    req_channel,
   input  wire logic signed [15:0]            req_value,
   input  wire logic [NUM_CH-1:0][BASE_W-1:0] base_ticks,
   input  wire logic                          take_ready,
   output cmd_type                            cmd
);

   // Stage valids
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in;
   logic rdy1, rdy2, rdy3, rdy4;

   // Stage 1: request register
   req_kind_type       s1_type_ff;
   logic [1:0]         s1_ch_ff;
   logic signed [15:0] s1_value_ff;

   // Stage 2: products
   req_kind_type             s2_type_ff;
   logic [1:0]               s2_ch_ff;
   logic signed [SUM_W-1:0]  s2_us_val_ff, s2_us_val_in;
   logic signed [32:0]       s2_rad_prod_ff, s2_rad_prod_in;
   logic [33:0]              s2_deg_prod_ff, s2_deg_prod_in;
   logic                     s2_deg_neg_ff;

   // Stage 3: saturated compare value
   req_kind_type s3_type_ff;
   logic [1:0]   s3_ch_ff;
   logic [15:0]  s3_cand_ff, s3_cand_in;

   // Stage 4: compare value and its microsecond form
   req_kind_type s4_type_ff;
   logic [1:0]   s4_ch_ff;
   logic [15:0]  s4_cand_ff;
   logic [14:0]  s4_us_ff, s4_us_in;

   // Ready chain: a stage loads when empty or when its item moves on
   assign rdy4 = !s4_valid_ff || take_ready;
   assign rdy3 = !s3_valid_ff || rdy4;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;
   assign req_stall = !rdy1;

   assign s1_valid_in = rdy1 ? req_valid   : s1_valid_ff;
   assign s2_valid_in = rdy2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = rdy3 ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in = rdy4 ? s3_valid_ff : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_type_ff  <= req_kind_type'(req_type);
         s1_ch_ff    <= req_channel;
         s1_value_ff <= req_value;
      end
   end

   // Form the three candidate products
   logic signed [SUM_W-1:0] val_ext;
   logic [15:0]             deg_mag;
   logic [20:0]             deg_mag25;
   logic [16:0]             deg_div8;

   always_comb begin
      val_ext        = {{(SUM_W-16){s1_value_ff[15]}}, s1_value_ff};
      s2_us_val_in   = val_ext * $signed(SUM_W'(TICKS_PER_US));
      s2_rad_prod_in = s1_value_ff * $signed({1'b0, RAD_GAIN_Q6});
      deg_mag        = s1_value_ff[15] ? (~s1_value_ff + 16'd1) : s1_value_ff;
      // times 25 as shifts and adds, then /24 as /8 and a reciprocal of 3
      deg_mag25      = ({5'b0, deg_mag} << 4) + ({5'b0, deg_mag} << 3) + {5'b0, deg_mag};
      deg_div8       = deg_mag25[19:3];
      s2_deg_prod_in = {17'b0, deg_div8} * {17'b0, DEG_RECIP};
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_type_ff     <= s1_type_ff;
         s2_ch_ff       <= s1_ch_ff;
         s2_us_val_ff   <= s2_us_val_in;
         s2_rad_prod_ff <= s2_rad_prod_in;
         s2_deg_prod_ff <= s2_deg_prod_in;
         s2_deg_neg_ff  <= s1_value_ff[15];
      end
   end

   // Add the neutral width to radian and degree offsets and saturate to 16 bits
   logic [32:0]             rad_sum;
   logic [14:0]             rad_q;
   logic [15:0]             deg_q;
   logic signed [SUM_W-1:0] rad_off, deg_mag_ext, deg_off, base_ext, sum;
   logic [BASE_W-1:0]       base_sel;

   always_comb begin
      // round the radian quotient toward zero
      rad_sum  = s2_rad_prod_ff[32] ? (s2_rad_prod_ff + 33'((2 ** RAD_SHIFT) - 1))
                                    : s2_rad_prod_ff;
      rad_q    = rad_sum[32:RAD_SHIFT];
      rad_off  = {{(SUM_W-15){rad_q[14]}}, rad_q};
      deg_q    = s2_deg_prod_ff[33:DEG_SHIFT];
      deg_mag_ext = {{(SUM_W-16){1'b0}}, deg_q};
      deg_off  = s2_deg_neg_ff ? (SUM_W'(0) - deg_mag_ext) : deg_mag_ext;
      case (s2_ch_ff)
         2'd0:    base_sel = base_ticks[0];
         2'd1:    base_sel = base_ticks[1];
         2'd2:    base_sel = base_ticks[2];
         default: base_sel = '0;
      endcase
      base_ext = {2'b00, base_sel};
      case (s2_type_ff)
         REQ_SET_US:  sum = s2_us_val_ff;
         REQ_SET_RAD: sum = base_ext + rad_off;
         REQ_SET_DEG: sum = base_ext + deg_off;
         default:     sum = '0;
      endcase
      if (sum[SUM_W-1]) begin
         s3_cand_in = 16'd0;
      end else if (|sum[SUM_W-2:16]) begin
         s3_cand_in = 16'hFFFF;
      end else begin
         s3_cand_in = sum[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_type_ff <= s2_type_ff;
         s3_ch_ff   <= s2_ch_ff;
         s3_cand_ff <= s3_cand_in;
      end
   end

   // Convert ticks to microseconds by reciprocal, saturate to 15 bits
   logic [16+US_RECIP_W-1:0] us_prod;
   logic [16:0]              us_q;

   always_comb begin
      us_prod  = {{US_RECIP_W{1'b0}}, s3_cand_ff} * {16'b0, US_RECIP};
      us_q     = us_prod[US_SHIFT+16:US_SHIFT];
      s4_us_in = (|us_q[16:15]) ? 15'h7FFF : us_q[14:0];
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_type_ff <= s3_type_ff;
         s4_ch_ff   <= s3_ch_ff;
         s4_cand_ff <= s3_cand_ff;
         s4_us_ff   <= s4_us_in;
      end
   end

   assign cmd.valid      = s4_valid_ff;
   assign cmd.req_type   = s4_type_ff;
   assign cmd.channel    = s4_ch_ff;
   assign cmd.cand_ticks = s4_cand_ff;
   assign cmd.cand_us    = s4_us_ff;

endmodule

`default_nettype wire

>>> rtl/three_channel_servo_pwm_unit.sv
// Top level of the three-channel servo pulse generator: registers, commit stage, result register.
`timescale 1ns / 1ps
`default_nettype none

// Three-channel servo pulse generator. Every request is a tick (advance the
// frame counter, which wraps after period_ticks) or a set-point for one
// channel given in microseconds, radians Q4.12 or 1/16 degrees; each request
// returns one result with the pin levels, a frame-start flag and the
// addressed channel's compare value in ticks and microseconds. The block
// takes one request per clock while req_stall is low; a request lands in the
// first of four set-point pipeline registers, passes through the others, and
// the commit stage after the last one updates the counter and compare values
// and loads the result register.
// Stall on the result side holds every full stage; req_stall rises only once
// all stages hold a request, so a bubble anywhere is absorbed first.
// Configuration registers at byte addresses 0x00 period_ticks,
// 0x04 enable_mask, 0x08/0x0C/0x10 neutral width of channels 0..2 in us.

module three_channel_servo_pwm_unit
   import tspwm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_type,
   input  wire logic [1:0]         req_channel,
   input  wire logic signed [15:0] req_value,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_pwm_out,
   output logic                    rsp_frame_start,
   output logic [15:0]             rsp_readback_ticks,
   output logic [14:0]             rsp_readback_us,
   // configuration port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [4:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   // Configuration
   logic [15:0]                    period_ff;
   logic [NUM_CH-1:0]              enable_ff;
   logic [NUM_CH-1:0][14:0]        neutral_ff;
   logic [NUM_CH-1:0][BASE_W-1:0]  base_ff;
   csr_index_type                  reg_index;
   logic                           cfg_write;
   logic [BASE_W-1:0]              base_in;

   assign pready    = 1'b1;
   assign reg_index = csr_index_type'(paddr[4:2]);
   assign cfg_write = psel && penable && pwrite && pready;
   assign base_in   = BASE_W'(pwdata[14:0]) * BASE_W'(TICKS_PER_US);

   // Write registers; keep the neutral width also in ticks
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= RESET_PERIOD;
         enable_ff  <= '0;
         for (int i = 0; i < NUM_CH; i++) begin
            neutral_ff[i] <= RESET_NEUTRAL;
            base_ff[i]    <= RESET_BASE;
         end
      end else if (cfg_write) begin
         case (reg_index)
            CSR_PERIOD:   period_ff <= pwdata[15:0];
            CSR_ENABLE:   enable_ff <= pwdata[NUM_CH-1:0];
            CSR_NEUTRAL0: begin
               neutral_ff[0] <= pwdata[14:0];
               base_ff[0]    <= base_in;
            end
            CSR_NEUTRAL1: begin
               neutral_ff[1] <= pwdata[14:0];
               base_ff[1]    <= base_in;
            end
            CSR_NEUTRAL2: begin
               neutral_ff[2] <= pwdata[14:0];
               base_ff[2]    <= base_in;
            end
            default: ;
         endcase
      end
   end

   // Read back registers
   always_comb begin
      case (reg_index)
         CSR_PERIOD:   prdata = {16'b0, period_ff};
         CSR_ENABLE:   prdata = {29'b0, enable_ff};
         CSR_NEUTRAL0: prdata = {17'b0, neutral_ff[0]};
         CSR_NEUTRAL1: prdata = {17'b0, neutral_ff[1]};
         CSR_NEUTRAL2: prdata = {17'b0, neutral_ff[2]};
         default:      prdata = '0;
      endcase
   end

   // Set-point pipeline
   cmd_type cmd;
   logic    out_free;
   logic    commit;

   assign out_free = !rsp_valid || !rsp_stall;
   assign commit   = cmd.valid && out_free;

   tspwm_setpoint u_setpoint (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_channel (req_channel),
      .req_value   (req_value),
      .base_ticks  (base_ff),
      .take_ready  (out_free),
      .cmd         (cmd)
   );

   // Servo state
   logic [15:0]             counter_ff, counter_in;
   logic [NUM_CH-1:0][15:0] compare_ff, compare_in;
   logic [NUM_CH-1:0][14:0] compare_us_ff, compare_us_in;
   logic                    wrap_in;
   logic [NUM_CH-1:0]       pins_in;
   logic [15:0]             rb_ticks_in;
   logic [14:0]             rb_us_in;

   // Advance the counter or load a compare value, then form the result
   always_comb begin
      counter_in    = counter_ff;
      compare_in    = compare_ff;
      compare_us_in = compare_us_ff;
      wrap_in       = 1'b0;
      if (cmd.req_type == REQ_TICK) begin
         if (counter_ff >= period_ff) begin
            counter_in = '0;
            wrap_in    = 1'b1;
         end else begin
            counter_in = counter_ff + 16'd1;
         end
      end else begin
         for (int i = 0; i < NUM_CH; i++) begin
            if (cmd.channel == 2'(i)) begin
               compare_in[i]    = cmd.cand_ticks;
               compare_us_in[i] = cmd.cand_us;
            end
         end
      end
      for (int i = 0; i < NUM_CH; i++) begin
         pins_in[i] = enable_ff[i] && (counter_in < compare_in[i]);
      end
      case (cmd.channel)
         2'd0: begin
            rb_ticks_in = compare_in[0];
            rb_us_in    = compare_us_in[0];
         end
         2'd1: begin
            rb_ticks_in = compare_in[1];
            rb_us_in    = compare_us_in[1];
         end
         2'd2: begin
            rb_ticks_in = compare_in[2];
            rb_us_in    = compare_us_in[2];
         end
         default: begin
            rb_ticks_in = '0;
            rb_us_in    = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         for (int i = 0; i < NUM_CH; i++) begin
            compare_ff[i]    <= RESET_COMPARE;
            compare_us_ff[i] <= RESET_COMPARE_US;
         end
      end else if (commit) begin
         counter_ff    <= counter_in;
         compare_ff    <= compare_in;
         compare_us_ff <= compare_us_in;
      end
   end

   // Result register: load on commit, drop once taken
   logic        rsp_valid_ff;
   logic [2:0]  rsp_pwm_out_ff;
   logic        rsp_frame_start_ff;
   logic [15:0] rsp_readback_ticks_ff;
   logic [14:0] rsp_readback_us_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_pwm_out_ff        <= pins_in;
         rsp_frame_start_ff    <= wrap_in;
         rsp_readback_ticks_ff <= rb_ticks_in;
         rsp_readback_us_ff    <= rb_us_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pwm_out        = rsp_pwm_out_ff;
   assign rsp_frame_start    = rsp_frame_start_ff;
   assign rsp_readback_ticks = rsp_readback_ticks_ff;
   assign rsp_readback_us    = rsp_readback_us_ff;

   // A wrapping tick leaves the counter at zero
   assert property (@(posedge clock) disable iff (reset)
      commit && wrap_in |=> counter_ff == 16'd0)
      else $error("counter not zero after frame wrap");

   // A set request leaves the counter alone
   assert property (@(posedge clock) disable iff (reset)
      commit && cmd.req_type != REQ_TICK |=> $stable(counter_ff))
      else $error("counter moved on a set request");

   // Microsecond readback is the tick readback divided down, unless saturated
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_readback_us_ff != 15'h7FFF |->
         (21'(rsp_readback_us_ff) * 21'(TICKS_PER_US) <= 21'(rsp_readback_ticks_ff)) &&
         (21'(rsp_readback_ticks_ff) <
          21'(rsp_readback_us_ff) * 21'(TICKS_PER_US) + 21'(TICKS_PER_US)))
      else $error("microsecond readback does not match ticks");

endmodule

`default_nettype wire
